// File: rtl/cwsmooth_pkg.sv
// shared types and constants for the center-weighted 3x3 smoothing core
// no dependencies; imported by the core and its port checker
package cwsmooth_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COUNT_BITS  = 9;
    localparam int CENTER_BITS = SAMPLE_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int SMOOTH_BITS = 17;
    localparam int POS_BITS    = 8;

    localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] ROW_LIMIT = COUNT_BITS'(MAX_ROWS);
    localparam logic [COUNT_BITS-1:0] COL_LIMIT = COUNT_BITS'(MAX_COLUMNS);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(256);

    localparam logic [SMOOTH_BITS-1:0] MAX_SMOOTHED = SMOOTH_BITS'(66991);

    // floor(x/5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2^18
    localparam int DIV5_BITS  = 18;
    localparam int DIV5_SHIFT = 20;
    localparam logic [DIV5_BITS-1:0] DIV5_MUL = DIV5_BITS'(209716);

    // floor(s/9) = (s * DIV9_MUL) >> DIV9_SHIFT, exact for s < 2^21
    localparam int DIV9_BITS  = 21;
    localparam int DIV9_SHIFT = 24;
    localparam logic [DIV9_BITS-1:0] DIV9_MUL = DIV9_BITS'(1864136);

    // configuration register indexes
    localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] height_sample;
        logic                   frame_start;
    } t_in_item;

    typedef struct packed {
        logic [SMOOTH_BITS-1:0] smoothed_height;
        logic [POS_BITS-1:0]    center_row;
        logic [POS_BITS-1:0]    center_column;
        logic                   last_of_frame;
    } t_out_item;

    function automatic logic [COUNT_BITS-1:0] clamp_count(
        input logic [COUNT_BITS-1:0] v,
        input logic [COUNT_BITS-1:0] hi
    );
        logic [COUNT_BITS-1:0] res;
        if (v < MIN_COUNT) begin
            res = MIN_COUNT;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: rtl/center_weighted_3x3_smoothing_core.sv
// center-weighted 3x3 smoothing core: line stores, window registers, weighted sum, divide by 9
// depends on cwsmooth_pkg
// throughput: one sample per cycle while i_out_ready does not stall the output;
//   the two line stores have one read and one write port each; pipeline: stage 1
//   holds the line store read, stage 2 the weighted sum, the result register the divide
// reset: synchronous active low; clears pipeline valids, position and window, and sets both
//   counts to 256; line store contents stay undefined until written
module center_weighted_3x3_smoothing_core
    import cwsmooth_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);

    // configuration
    logic [COUNT_BITS-1:0] r_row_count;
    logic [COUNT_BITS-1:0] r_column_count;

    // position of the next sample
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;

    // line stores: top holds row r-2, mid holds row r-1
    logic [SAMPLE_BITS-1:0] r_top_mem [MAX_COLUMNS];
    logic [SAMPLE_BITS-1:0] r_mid_mem [MAX_COLUMNS];
    logic [SAMPLE_BITS-1:0] r_q_top;
    logic [SAMPLE_BITS-1:0] r_q_mid;

    // stage 1
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [COL_BITS-1:0]    r_s1_col;
    logic                   r_s1_emit;
    logic                   r_s1_last;
    logic [POS_BITS-1:0]    r_s1_crow;
    logic [POS_BITS-1:0]    r_s1_ccol;
    logic                   r_fwd;
    logic [SAMPLE_BITS-1:0] r_fwd_top;
    logic [SAMPLE_BITS-1:0] r_fwd_mid;

    // window columns c-2 (0..2) and c-1 (3..5), plus weighted copy of entry 4
    logic [SAMPLE_BITS-1:0] r_win [6];
    logic [CENTER_BITS-1:0] r_center_w;

    // stage 2
    logic                   r_s2_valid;
    logic [SUM_BITS-1:0]    r_s2_sum;
    logic [POS_BITS-1:0]    r_s2_crow;
    logic [POS_BITS-1:0]    r_s2_ccol;
    logic                   r_s2_last;

    // result register
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   in_accept;
    logic                   out_free;
    logic                   en2;
    logic                   s1_go;
    logic [COUNT_BITS-1:0]  rows_eff;
    logic [COUNT_BITS-1:0]  cols_eff;
    logic [ROW_BITS-1:0]    row0;
    logic [COL_BITS-1:0]    col0;
    logic [COUNT_BITS-1:0]  row_ext;
    logic [COUNT_BITS-1:0]  col_ext;
    logic                   emit0;
    logic                   last0;
    logic [ROW_BITS-1:0]    n_row;
    logic [COL_BITS-1:0]    n_col;
    logic                   fwd0;
    logic [SAMPLE_BITS-1:0] top_eff;
    logic [SAMPLE_BITS-1:0] mid_eff;
    logic [SAMPLE_BITS+DIV5_BITS-1:0] prod5;
    logic [CENTER_BITS-1:0] n_center_w;
    logic [SUM_BITS-1:0]    sum1;
    logic [SUM_BITS+DIV9_BITS-1:0] prod9;

    assign out_free   = !r_out_valid || i_out_ready;
    assign en2        = !r_s2_valid || out_free;
    assign s1_go      = r_s1_valid && en2;
    assign o_in_ready = !r_s1_valid || en2;
    assign in_accept  = i_in_valid && o_in_ready;

    assign rows_eff = clamp_count(r_row_count, ROW_LIMIT);
    assign cols_eff = clamp_count(r_column_count, COL_LIMIT);

    always_comb begin
        row0    = i_in.frame_start ? '0 : r_row;
        col0    = i_in.frame_start ? '0 : r_col;
        row_ext = COUNT_BITS'(row0);
        col_ext = COUNT_BITS'(col0);
        emit0   = (row_ext >= COUNT_BITS'(2)) && (col_ext >= COUNT_BITS'(2))
                  && (row_ext < rows_eff) && (col_ext < cols_eff);
        last0   = (row_ext == rows_eff - COUNT_BITS'(1))
                  && (col_ext == cols_eff - COUNT_BITS'(1));
        if (col_ext + COUNT_BITS'(1) >= cols_eff) begin
            n_col = '0;
            if (row_ext + COUNT_BITS'(1) >= rows_eff) begin
                n_row = '0;
            end else begin
                n_row = row0 + ROW_BITS'(1);
            end
        end else begin
            n_col = col0 + COL_BITS'(1);
            n_row = row0;
        end
        // the item leaving stage 1 writes the entry this request reads
        fwd0 = s1_go && (r_s1_col == col0);
    end

    assign top_eff = r_fwd ? r_fwd_top : r_q_top;
    assign mid_eff = r_fwd ? r_fwd_mid : r_q_mid;

    // center weight 6/5: x + floor(x/5)
    assign prod5      = {{DIV5_BITS{1'b0}}, mid_eff} * {{SAMPLE_BITS{1'b0}}, DIV5_MUL};
    assign n_center_w = CENTER_BITS'(mid_eff)
                        + CENTER_BITS'(prod5[SAMPLE_BITS+DIV5_BITS-1:DIV5_SHIFT]);

    assign sum1 = SUM_BITS'(r_win[0]) + SUM_BITS'(r_win[1]) + SUM_BITS'(r_win[2])
                + SUM_BITS'(r_win[3]) + SUM_BITS'(r_win[5])
                + SUM_BITS'(top_eff) + SUM_BITS'(mid_eff) + SUM_BITS'(r_s1_sample)
                + SUM_BITS'(r_center_w);

    assign prod9 = {{DIV9_BITS{1'b0}}, r_s2_sum} * {{SUM_BITS{1'b0}}, DIV9_MUL};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= COUNT_RESET;
            r_column_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                REG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line stores
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_top_mem[r_s1_col] <= mid_eff;
            r_mid_mem[r_s1_col] <= r_s1_sample;
        end
        if (in_accept) begin
            r_q_top <= r_top_mem[col0];
            r_q_mid <= r_mid_mem[col0];
        end
    end

    // position and stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= i_in.height_sample;
            r_s1_col    <= col0;
            r_s1_emit   <= emit0;
            r_s1_last   <= last0;
            r_s1_crow   <= POS_BITS'(row0 - ROW_BITS'(1));
            r_s1_ccol   <= POS_BITS'(col0 - COL_BITS'(1));
            r_fwd       <= fwd0;
            r_fwd_top   <= mid_eff;
            r_fwd_mid   <= r_s1_sample;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_center_w <= '0;
        end else if (s1_go) begin
            r_win[0]   <= r_win[3];
            r_win[1]   <= r_win[4];
            r_win[2]   <= r_win[5];
            r_win[3]   <= top_eff;
            r_win[4]   <= mid_eff;
            r_win[5]   <= r_s1_sample;
            r_center_w <= n_center_w;
        end
    end

    // stage 2 and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en2) begin
                r_s2_valid <= s1_go && r_s1_emit;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_sum  <= sum1;
            r_s2_crow <= r_s1_crow;
            r_s2_ccol <= r_s1_ccol;
            r_s2_last <= r_s1_last;
        end
        if (out_free && r_s2_valid) begin
            r_out.smoothed_height <= prod9[DIV9_SHIFT +: SMOOTH_BITS];
            r_out.center_row      <= r_s2_crow;
            r_out.center_column   <= r_s2_ccol;
            r_out.last_of_frame   <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/cwsmooth_checker.sv
// port-level checks for the center-weighted 3x3 smoothing core
// depends on cwsmooth_pkg; bound to center_weighted_3x3_smoothing_core below
module cwsmooth_checker
    import cwsmooth_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // weighted average never exceeds the 6/5-weighted full scale
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.smoothed_height <= MAX_SMOOTHED)
        else $error("smoothed height out of range");

    // only interior centers produce results
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.center_row != '0) && (o_out.center_column != '0)
                        && (o_out.center_row != '1) && (o_out.center_column != '1))
        else $error("result for a border center");

endmodule

bind center_weighted_3x3_smoothing_core cwsmooth_checker u_cwsmooth_checker (.*);
